// ===== hw/rtl/dms_coordinate_parser_defines.svh =====
// Assertion macros shared by the coordinate parser RTL.
// Depends on nothing; expects signals named clk and rst_n at the point of use.
`ifndef DMS_COORDINATE_PARSER_DEFINES_SVH
`define DMS_COORDINATE_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DMSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DMSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dmsc_pkg.sv =====
// Shared types, constants and helpers of the coordinate parser.
// No dependencies.
package dmsc_pkg;

    // Default width of one collected number
    localparam int NUMBER_BITS_DEF = 16;

    // Fixed field widths
    localparam int CHAR_BITS   = 8;
    localparam int ARC_BITS    = 29;
    localparam int HEMI_BITS   = 3;
    localparam int COUNT_BITS  = 2;
    localparam int DIGIT_BITS  = 4;
    localparam int WEIGHT_BITS = 12;

    // Number count after degrees, minutes and seconds
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = 2'd3;

    // Ninety degrees in arcseconds
    localparam logic [ARC_BITS-1:0] QUARTER_ARCSEC = 29'd324000;

    // Byte codes
    localparam logic [CHAR_BITS-1:0] CHAR_0 = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_9 = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_N = 8'h4E;
    localparam logic [CHAR_BITS-1:0] CHAR_S = 8'h53;
    localparam logic [CHAR_BITS-1:0] CHAR_E = 8'h45;
    localparam logic [CHAR_BITS-1:0] CHAR_W = 8'h57;

    // Hemisphere codes
    typedef enum logic [HEMI_BITS-1:0] {
        HEMI_NONE = 3'd0,
        HEMI_N    = 3'd1,
        HEMI_S    = 3'd2,
        HEMI_E    = 3'd3,
        HEMI_W    = 3'd4
    } hemi_t;

    // Control handed from the byte stage to the parser
    typedef struct packed {
        logic step;
        logic last;
        logic lon;
    } step_ctrl_t;

    // Weight of the number at a given position: degrees, minutes, seconds
    function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [COUNT_BITS-1:0] idx);
        logic [WEIGHT_BITS-1:0] w;
        case (idx)
            2'd0:    w = 12'd3600;
            2'd1:    w = 12'd60;
            2'd2:    w = 12'd1;
            default: w = 12'd0;
        endcase
        return w;
    endfunction

    // Map a byte to its hemisphere code
    function automatic hemi_t classify_letter(input logic [CHAR_BITS-1:0] c);
        hemi_t h;
        case (c)
            CHAR_N:  h = HEMI_N;
            CHAR_S:  h = HEMI_S;
            CHAR_E:  h = HEMI_E;
            CHAR_W:  h = HEMI_W;
            default: h = HEMI_NONE;
        endcase
        return h;
    endfunction

endpackage

// ===== hw/rtl/dmsc_parse.sv =====
// Parse state and per-byte update of the coordinate parser.
// Depends on dmsc_pkg.
module dmsc_parse #(
    parameter int NUMBER_BITS = dmsc_pkg::NUMBER_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dmsc_pkg::step_ctrl_t                 ctrl,
    input  logic [dmsc_pkg::CHAR_BITS-1:0]       char_code,
    output logic signed [dmsc_pkg::ARC_BITS-1:0] arcseconds,
    output dmsc_pkg::hemi_t                      hemisphere,
    output logic [dmsc_pkg::COUNT_BITS-1:0]      numbers_found
);
    import dmsc_pkg::*;

    localparam int WIDE_BITS  = NUMBER_BITS + DIGIT_BITS;
    localparam int TOTAL_BITS = NUMBER_BITS + WEIGHT_BITS;
    localparam int EXT_BITS   = (TOTAL_BITS > ARC_BITS) ? TOTAL_BITS : ARC_BITS;
    localparam logic [NUMBER_BITS-1:0] NUMBER_MAX = '1;

    // Parse state
    logic [COUNT_BITS-1:0]  count_reg,  count_next;
    logic                   seen_reg,   seen_next;
    logic [NUMBER_BITS-1:0] num_reg,    num_next;
    logic [TOTAL_BITS-1:0]  total_reg,  total_next;
    logic                   expect_reg, expect_next;
    hemi_t                  letter_reg, letter_next;

    logic                   is_digit;
    logic                   counting;
    logic                   finish;
    logic [CHAR_BITS-1:0]   digit_diff;
    logic [WIDE_BITS-1:0]   num_wide;
    logic [NUMBER_BITS-1:0] num_sat;
    logic [NUMBER_BITS-1:0] fin_num;
    logic [TOTAL_BITS-1:0]  product;
    logic [TOTAL_BITS-1:0]  total_sum;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [EXT_BITS-1:0]    total_ext;
    logic [ARC_BITS-1:0]    total_arc;
    hemi_t                  letter_now;

    // Classify the byte and extend the number in progress
    always_comb
    begin
        is_digit   = char_code inside {[CHAR_0:CHAR_9]};
        counting   = (count_reg != COUNT_FULL);
        digit_diff = char_code - CHAR_0;
        num_wide   = ({{DIGIT_BITS{1'b0}}, num_reg} << 3)
                   + ({{DIGIT_BITS{1'b0}}, num_reg} << 1)
                   + WIDE_BITS'(digit_diff[DIGIT_BITS-1:0]);
        num_sat    = (num_wide > {{DIGIT_BITS{1'b0}}, NUMBER_MAX})
                   ? NUMBER_MAX : num_wide[NUMBER_BITS-1:0];
    end

    // Weight and add a number ended by a non-digit or by the end of the token
    always_comb
    begin
        finish    = counting && ((!is_digit && seen_reg) || (is_digit && ctrl.last));
        fin_num   = is_digit ? num_sat : num_reg;
        product   = TOTAL_BITS'(fin_num) * TOTAL_BITS'(weight_of(count_reg));
        total_sum = total_reg + product;
        count_inc = count_reg + 2'd1;
    end

    // Next state for one byte
    always_comb
    begin
        count_next  = count_reg;
        seen_next   = seen_reg;
        num_next    = num_reg;
        total_next  = total_reg;
        expect_next = expect_reg;
        letter_next = letter_reg;
        letter_now  = letter_reg;
        if (counting)
        begin
            if (is_digit)
            begin
                seen_next = 1'b1;
                num_next  = num_sat;
            end
            else if (seen_reg)
            begin
                seen_next   = 1'b0;
                num_next    = '0;
                count_next  = count_inc;
                total_next  = total_sum;
                expect_next = (count_inc == COUNT_FULL);
            end
        end
        else if (expect_reg)
        begin
            letter_now  = classify_letter(char_code);
            letter_next = letter_now;
            expect_next = 1'b0;
        end
        // Drop all state at the end of the token
        if (ctrl.last)
        begin
            count_next  = '0;
            seen_next   = 1'b0;
            num_next    = '0;
            total_next  = '0;
            expect_next = 1'b0;
            letter_next = HEMI_NONE;
        end
    end

    // Final value for a last byte
    always_comb
    begin
        total_ext     = EXT_BITS'(finish ? total_sum : total_reg);
        total_arc     = total_ext[ARC_BITS-1:0];
        hemisphere    = letter_now;
        numbers_found = finish ? count_inc : count_reg;
        arcseconds    = signed'(total_arc);
        if (!ctrl.lon)
        begin
            if (letter_now == HEMI_N)
            begin
                arcseconds = signed'(QUARTER_ARCSEC - total_arc);
            end
            else if (letter_now == HEMI_S)
            begin
                arcseconds = signed'(QUARTER_ARCSEC + total_arc);
            end
        end
        else if (letter_now == HEMI_W)
        begin
            arcseconds = signed'(ARC_BITS'(0) - total_arc);
        end
    end

    // Advance state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            seen_reg   <= 1'b0;
            num_reg    <= '0;
            total_reg  <= '0;
            expect_reg <= 1'b0;
            letter_reg <= HEMI_NONE;
        end
        else if (ctrl.step)
        begin
            count_reg  <= count_next;
            seen_reg   <= seen_next;
            num_reg    <= num_next;
            total_reg  <= total_next;
            expect_reg <= expect_next;
            letter_reg <= letter_next;
        end
    end

endmodule

// ===== hw/rtl/dms_coordinate_parser.sv =====
// Top level of the degrees-minutes-seconds coordinate parser.
// Depends on dmsc_pkg, dmsc_parse and dms_coordinate_parser_defines.svh.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+---------------------------------------------
//  byte    | byte_valid / byte_stall     | char_code, is_longitude, last_char
//  result  | result_valid / result_stall | arcseconds, hemisphere, numbers_found
//
// One byte per cycle unless a last byte waits on a stalled result; a byte is captured in the
// input register on transfer and processed from there when it advances, and the result of a
// last byte is valid from the edge at which that byte is processed.
// Reset clears the parse state and both valid registers; no clearing pass.
// A stalled result holds the input register only when it holds a last byte;
// other bytes keep flowing.
`include "dms_coordinate_parser_defines.svh"

module dms_coordinate_parser #(
    parameter int NUMBER_BITS = dmsc_pkg::NUMBER_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 byte_valid,
    output logic                                 byte_stall,
    input  logic [dmsc_pkg::CHAR_BITS-1:0]       char_code,
    input  logic                                 is_longitude,
    input  logic                                 last_char,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [dmsc_pkg::ARC_BITS-1:0] arcseconds,
    output logic [dmsc_pkg::HEMI_BITS-1:0]       hemisphere,
    output logic [dmsc_pkg::COUNT_BITS-1:0]      numbers_found
);
    import dmsc_pkg::*;

    // Input register
    logic                 byte_vld_reg, byte_vld_next;
    logic [CHAR_BITS-1:0] char_reg;
    logic                 lon_reg;
    logic                 last_reg;

    // Result register
    logic                        res_vld_reg, res_vld_next;
    logic signed [ARC_BITS-1:0]  arc_reg;
    hemi_t                       hemi_reg;
    logic [COUNT_BITS-1:0]       found_reg;

    logic                        byte_take;
    logic                        res_free;
    logic                        adv;
    step_ctrl_t                  ctrl;
    logic signed [ARC_BITS-1:0]  arc_now;
    hemi_t                       hemi_now;
    logic [COUNT_BITS-1:0]       found_now;

    // Handshake: a non-last byte always advances, a last byte needs room
    always_comb
    begin
        res_free      = !res_vld_reg || !result_stall;
        adv           = byte_vld_reg && (!last_reg || res_free);
        byte_stall    = byte_vld_reg && !adv;
        byte_take     = byte_valid && !byte_stall;
        byte_vld_next = byte_take ? 1'b1 : (adv ? 1'b0 : byte_vld_reg);
        res_vld_next  = (adv && last_reg) ? 1'b1
                      : ((res_vld_reg && !result_stall) ? 1'b0 : res_vld_reg);
        ctrl.step     = adv;
        ctrl.last     = last_reg;
        ctrl.lon      = lon_reg;
    end

    dmsc_parse #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .char_code     (char_reg),
        .arcseconds    (arc_now),
        .hemisphere    (hemi_now),
        .numbers_found (found_now)
    );

    // Valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            byte_vld_reg <= byte_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Capture an accepted byte
    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            char_reg <= char_code;
            lon_reg  <= is_longitude;
            last_reg <= last_char;
        end
    end

    // Capture the result of a last byte
    always_ff @(posedge clk)
    begin
        if (adv && last_reg)
        begin
            arc_reg   <= arc_now;
            hemi_reg  <= hemi_now;
            found_reg <= found_now;
        end
    end

    assign result_valid  = res_vld_reg;
    assign arcseconds    = arc_reg;
    assign hemisphere    = hemi_reg;
    assign numbers_found = found_reg;

    // Checks
    `DMSC_ASSERT_NEXT(a_last_gives_result, adv && last_reg, res_vld_reg,
        "last byte processed without a result")
    `DMSC_ASSERT_NEXT(a_byte_held, byte_vld_reg && !adv, byte_vld_reg,
        "held byte lost from the input register")
    `DMSC_ASSERT_NOW(a_letter_after_three, res_vld_reg && (found_reg != COUNT_FULL),
        hemi_reg == HEMI_NONE, "hemisphere reported before three numbers")
    `DMSC_ASSERT_NOW(a_no_overwrite, res_vld_reg && result_stall, !(adv && last_reg),
        "stalled result overwritten")

endmodule
